// File: rtl/linear_probe_kv_store_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the key store
// Shared concurrent assertion forms, clocked and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef LINEAR_PROBE_KV_STORE_TOP_MACROS_SVH
`define LINEAR_PROBE_KV_STORE_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LPKV_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LPKV_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/lpkv_pkg.sv
// ----------------------------------------------------------------------------
// lpkv_pkg
// Command, status and state codes shared by the key store modules.
// ----------------------------------------------------------------------------
package lpkv_pkg;

	typedef enum logic [1:0] {
		CMD_GET_OR_ADD = 2'd0,
		CMD_LOOKUP     = 2'd1,
		CMD_SET_WORD   = 2'd2,
		CMD_CLEAR      = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_OK         = 3'd0,
		ST_NOT_FOUND  = 3'd1,
		ST_TABLE_FULL = 3'd2,
		ST_DATA_FULL  = 3'd3,
		ST_BAD_INDEX  = 3'd4
	} status_t;

	typedef enum logic [7:0] {
		S_IDLE   = 8'b0000_0001,
		S_SWEEP  = 8'b0000_0010,
		S_START  = 8'b0000_0100,
		S_PROBE  = 8'b0000_1000,
		S_CHECK  = 8'b0001_0000,
		S_COMMIT = 8'b0010_0000,
		S_DREAD  = 8'b0100_0000,
		S_DONE   = 8'b1000_0000
	} state_t;

	localparam logic REG_VEC_LEN     = 1'b0;
	localparam logic REG_PROBE_LIMIT = 1'b1;

	localparam logic [6:0] VEC_LEN_RESET     = 7'd1;
	localparam logic [5:0] PROBE_LIMIT_RESET = 6'd32;
	localparam int         PROBE_CAP         = 32;

	typedef struct packed {
		logic we;
		logic re;
	} data_ctl_t;

endpackage

// File: rtl/lpkv_if.sv
// ----------------------------------------------------------------------------
// lpkv_in_if / lpkv_out_if
// Valid/ready channels for command items and result items.
// ----------------------------------------------------------------------------
interface lpkv_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  command;
	logic [63:0] key;
	logic [5:0]  word_index;
	logic [31:0] value_word;
	logic        mark_immutable;

	modport source (output valid, command, key, word_index, value_word, mark_immutable,
		input ready);
	modport sink (input valid, command, key, word_index, value_word, mark_immutable,
		output ready);
endinterface

interface lpkv_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic        found;
	logic [9:0]  slot_index;
	logic [13:0] data_offset;
	logic        new_entry;
	logic        entry_immutable;
	logic [31:0] word_out;

	modport source (output valid, status, found, slot_index, data_offset, new_entry,
		entry_immutable, word_out, input ready);
	modport sink (input valid, status, found, slot_index, data_offset, new_entry,
		entry_immutable, word_out, output ready);
endinterface

// File: rtl/lpkv_data_store.sv
// ----------------------------------------------------------------------------
// lpkv_data_store
// Value word memory with registered read; the first words read as zero
// until they are written.
// ----------------------------------------------------------------------------
`include "linear_probe_kv_store_top_macros.svh"

module lpkv_data_store #(
	parameter int DATA_WORDS    = 16384,
	parameter int MAX_VALUE_LEN = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  lpkv_pkg::data_ctl_t           ctl,
	input  logic [$clog2(DATA_WORDS)-1:0] addr,
	input  logic [31:0]                   wdata,
	output logic [31:0]                   rdata
);
	import lpkv_pkg::*;

	localparam int AW = $clog2(DATA_WORDS);
	localparam int FW = (MAX_VALUE_LEN > 1) ? $clog2(MAX_VALUE_LEN) : 1;

	logic [31:0]              mem [DATA_WORDS];
	logic [31:0]              rd_q;
	logic                     rd_zero_q;
	logic [MAX_VALUE_LEN-1:0] dval_q;
	logic                     first_word;

	assign first_word = ({1'b0, addr} < (AW+1)'(MAX_VALUE_LEN));

	always_ff @(posedge clk) begin
		if (ctl.we) begin
			mem[addr] <= wdata;
		end
		if (ctl.re) begin
			rd_q <= mem[addr];
		end
	end

	// The first words stand as zero after reset until written.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dval_q    <= '0;
			rd_zero_q <= 1'b1;
		end else begin
			if (ctl.we && first_word) begin
				dval_q[addr[FW-1:0]] <= 1'b1;
			end
			if (ctl.re) begin
				rd_zero_q <= first_word && !dval_q[addr[FW-1:0]];
			end
		end
	end

	assign rdata = rd_zero_q ? 32'd0 : rd_q;

	`LPKV_ASSERT_NOW(a_we_re_excl, clk, arst_n, ctl.we, !ctl.re, "data write and read together")
	`LPKV_ASSERT_NEXT(a_first_mark, clk, arst_n, ctl.we && first_word,
		dval_q[$past(addr[FW-1:0])], "first word not marked after write")
	`LPKV_ASSERT_NEXT(a_read_hold, clk, arst_n, !ctl.re && !ctl.we,
		$stable(rdata), "read data changed without access")

endmodule

// File: rtl/linear_probe_kv_store_top.sv
// ----------------------------------------------------------------------------
// linear_probe_kv_store_top
// Linear-probing hash table mapping 64-bit keys to vectors of value words.
// ----------------------------------------------------------------------------
// Usage: command items enter on in_ch (valid/ready) and each produces exactly
// one result item on out_ch. Items are handled one at a time. The slot table
// is a single-port synchronous memory; each probe has two steps, a slot read
// in S_PROBE and a compare of its key in S_CHECK. A non-clear item passes
// S_START, its probes, then S_COMMIT and S_DREAD before it waits in S_DONE.
// An item that ends without a commit (missing key, probes exhausted, no data
// space, word offset out of range) goes from S_CHECK straight to S_DONE, and
// a word index error goes from S_START straight to S_DONE.
// A clear item sweeps every slot of the table, one per cycle, then goes to
// S_DONE. After reset the same sweep runs with in_ch.ready low, and leaves
// key 0 as an immutable entry at offset 0.
// The result sits in an output register: while the receiver stalls, the
// next item is accepted and worked on, and it waits in its final state until
// the output register is free. The vector length and probe limit registers
// are written over the APB port at byte addresses 0 and 4, by the user while
// the block is idle (the block does not enforce this); pready is always high.
// ----------------------------------------------------------------------------
`include "linear_probe_kv_store_top_macros.svh"

module linear_probe_kv_store_top #(
	parameter int SLOTS         = 1024,
	parameter int DATA_WORDS    = 16384,
	parameter int MAX_VALUE_LEN = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	lpkv_in_if.sink     in_ch,
	lpkv_out_if.source  out_ch,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import lpkv_pkg::*;

	localparam int SW   = $clog2(SLOTS);
	localparam int AW   = $clog2(DATA_WORDS);
	localparam int ECW  = $clog2(SLOTS + 1);
	localparam int CW   = (ECW + 8 > AW + 1) ? ECW + 8 : AW + 1;
	localparam int SLW  = 2 + AW + 64;
	localparam int PCAP = (SLOTS < PROBE_CAP) ? SLOTS : PROBE_CAP;

	// Slot word layout: valid, immutable, offset, key.
	logic [SLW-1:0] slot_mem [SLOTS];
	logic [SLW-1:0] slot_rd_q;
	logic [SLW-1:0] slot_wdata;
	logic [SW-1:0]  slot_waddr;
	logic           slot_we;
	logic           slot_re;
	logic           rd_valid;
	logic           rd_imm;
	logic [AW-1:0]  rd_off;
	logic [63:0]    rd_key;

	state_t         state_q;
	logic           init_q;
	logic [SW-1:0]  sweep_q;
	logic [6:0]     vec_len_q;
	logic [5:0]     probe_limit_q;
	logic [ECW-1:0] entry_count_q;

	cmd_t           cmd_q;
	logic [63:0]    key_q;
	logic [5:0]     widx_q;
	logic [31:0]    vword_q;
	logic           mark_q;
	logic [6:0]     vlen_q;
	logic [5:0]     plim_q;
	logic [SW-1:0]  probe_idx_q;
	logic [5:0]     probe_cnt_q;
	logic [CW-1:0]  noff_q;

	status_t        res_status_q;
	logic           res_found_q;
	logic [SW-1:0]  res_slot_q;
	logic [AW-1:0]  res_off_q;
	logic           res_new_q;
	logic           res_imm_q;
	logic [31:0]    res_word_q;

	logic           out_valid_q;
	status_t        out_status_q;
	logic           out_found_q;
	logic [SW-1:0]  out_slot_q;
	logic [AW-1:0]  out_off_q;
	logic           out_new_q;
	logic           out_imm_q;
	logic [31:0]    out_word_q;

	logic [6:0]     vlen_eff;
	logic [5:0]     plim_eff;
	logic           in_acc;
	logic           out_load;
	logic           cfg_wr;
	logic           imm_final;
	data_ctl_t      dctl;
	logic [AW-1:0]  daddr;
	logic [31:0]    drdata;

	assign {rd_valid, rd_imm, rd_off, rd_key} = slot_rd_q;

	// Register values outside their meaningful range are pinned to the
	// nearest legal value when an item starts.
	always_comb begin
		vlen_eff = vec_len_q;
		if (vec_len_q == 7'd0) begin
			vlen_eff = 7'd1;
		end else if ({25'd0, vec_len_q} > 32'(MAX_VALUE_LEN)) begin
			vlen_eff = 7'(MAX_VALUE_LEN);
		end
		plim_eff = probe_limit_q;
		if (probe_limit_q == 6'd0) begin
			plim_eff = 6'd1;
		end else if ({26'd0, probe_limit_q} > 32'(PCAP)) begin
			plim_eff = 6'(PCAP);
		end
	end

	// Configuration port.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vec_len_q     <= VEC_LEN_RESET;
			probe_limit_q <= PROBE_LIMIT_RESET;
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_VEC_LEN:     vec_len_q     <= pwdata[6:0];
				REG_PROBE_LIMIT: probe_limit_q <= pwdata[5:0];
				default:         vec_len_q     <= vec_len_q;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_VEC_LEN:     prdata = {25'd0, vec_len_q};
			REG_PROBE_LIMIT: prdata = {26'd0, probe_limit_q};
			default:         prdata = 32'd0;
		endcase
	end

	assign in_ch.ready = (state_q == S_IDLE);
	assign in_acc      = in_ch.valid && in_ch.ready;
	assign out_load    = (state_q == S_DONE) && (!out_valid_q || out_ch.ready);

	// The final immutable mark: set_word writes it, an insert starts clear.
	assign imm_final = (cmd_q == CMD_SET_WORD) ? mark_q : (res_new_q ? 1'b0 : res_imm_q);

	// Slot table access.
	always_comb begin
		slot_we    = 1'b0;
		slot_re    = 1'b0;
		slot_waddr = probe_idx_q;
		slot_wdata = {1'b1, imm_final, res_off_q, key_q};
		case (state_q)
			S_SWEEP: begin
				slot_we    = 1'b1;
				slot_waddr = sweep_q;
				slot_wdata = '0;
				if (init_q && sweep_q == '0) begin
					slot_wdata = {1'b1, 1'b1, {AW{1'b0}}, 64'd0};
				end
			end
			S_PROBE:  slot_re = 1'b1;
			S_COMMIT: slot_we = res_new_q || (cmd_q == CMD_SET_WORD);
			default:  slot_we = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (slot_we) begin
			slot_mem[slot_waddr] <= slot_wdata;
		end
		if (slot_re) begin
			slot_rd_q <= slot_mem[probe_idx_q];
		end
	end

	// Data words: set_word writes, the other commands that reach S_COMMIT read back.
	always_comb begin
		dctl.we = (state_q == S_COMMIT) && (cmd_q == CMD_SET_WORD);
		dctl.re = (state_q == S_COMMIT) && (cmd_q != CMD_SET_WORD);
	end
	assign daddr = res_off_q + AW'(widx_q);

	lpkv_data_store #(
		.DATA_WORDS    (DATA_WORDS),
		.MAX_VALUE_LEN (MAX_VALUE_LEN)
	) u_data (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (dctl),
		.addr   (daddr),
		.wdata  (vword_q),
		.rdata  (drdata)
	);

	// Control sequence.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_SWEEP;
			init_q        <= 1'b1;
			sweep_q       <= '0;
			entry_count_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						if (cmd_t'(in_ch.command) == CMD_CLEAR) begin
							state_q <= S_SWEEP;
							sweep_q <= '0;
						end else begin
							state_q <= S_START;
						end
					end
				end
				S_SWEEP: begin
					sweep_q <= sweep_q + 1'b1;
					if (sweep_q == SW'(SLOTS - 1)) begin
						init_q <= 1'b0;
						if (init_q) begin
							entry_count_q <= ECW'(1);
							state_q       <= S_IDLE;
						end else begin
							entry_count_q <= '0;
							state_q       <= S_DONE;
						end
					end
				end
				S_START: begin
					if ({1'b0, widx_q} >= vlen_q) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_PROBE;
					end
				end
				S_PROBE: state_q <= S_CHECK;
				S_CHECK: begin
					if (!rd_valid) begin
						if (cmd_q == CMD_LOOKUP ||
							(noff_q + CW'(vlen_q)) > CW'(DATA_WORDS)) begin
							state_q <= S_DONE;
						end else begin
							state_q <= S_COMMIT;
						end
					end else if (rd_key == key_q) begin
						if (({1'b0, rd_off} + (AW+1)'(widx_q)) >= (AW+1)'(DATA_WORDS)) begin
							state_q <= S_DONE;
						end else begin
							state_q <= S_COMMIT;
						end
					end else if (probe_cnt_q + 6'd1 == plim_q) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_PROBE;
					end
				end
				S_COMMIT: begin
					if (res_new_q) begin
						entry_count_q <= entry_count_q + 1'b1;
					end
					state_q <= S_DREAD;
				end
				S_DREAD: state_q <= S_DONE;
				S_DONE: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Item and result registers.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					cmd_q        <= cmd_t'(in_ch.command);
					key_q        <= in_ch.key;
					widx_q       <= in_ch.word_index;
					vword_q      <= in_ch.value_word;
					mark_q       <= in_ch.mark_immutable;
					vlen_q       <= vlen_eff;
					plim_q       <= plim_eff;
					probe_idx_q  <= in_ch.key[SW-1:0];
					probe_cnt_q  <= 6'd0;
					res_status_q <= ST_OK;
					res_found_q  <= 1'b0;
					res_slot_q   <= '0;
					res_off_q    <= '0;
					res_new_q    <= 1'b0;
					res_imm_q    <= 1'b0;
					res_word_q   <= 32'd0;
				end
			end
			S_START: begin
				noff_q <= CW'(entry_count_q) * CW'(vlen_q);
				if ({1'b0, widx_q} >= vlen_q) begin
					res_status_q <= ST_BAD_INDEX;
				end
			end
			S_CHECK: begin
				if (!rd_valid) begin
					if (cmd_q == CMD_LOOKUP) begin
						res_status_q <= ST_NOT_FOUND;
					end else if ((noff_q + CW'(vlen_q)) > CW'(DATA_WORDS)) begin
						res_status_q <= ST_DATA_FULL;
					end else begin
						res_slot_q <= probe_idx_q;
						res_off_q  <= noff_q[AW-1:0];
						res_new_q  <= 1'b1;
					end
				end else if (rd_key == key_q) begin
					if (({1'b0, rd_off} + (AW+1)'(widx_q)) >= (AW+1)'(DATA_WORDS)) begin
						res_status_q <= ST_BAD_INDEX;
					end else begin
						res_slot_q <= probe_idx_q;
						res_off_q  <= rd_off;
						res_imm_q  <= rd_imm;
					end
				end else if (probe_cnt_q + 6'd1 == plim_q) begin
					res_status_q <= ST_TABLE_FULL;
				end else begin
					probe_idx_q <= probe_idx_q + 1'b1;
					probe_cnt_q <= probe_cnt_q + 6'd1;
				end
			end
			S_COMMIT: begin
				res_imm_q   <= imm_final;
				res_found_q <= 1'b1;
			end
			S_DREAD: begin
				res_word_q <= (cmd_q == CMD_SET_WORD) ? vword_q : drdata;
			end
			default: res_word_q <= res_word_q;
		endcase
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_status_q <= res_status_q;
			out_found_q  <= res_found_q;
			out_slot_q   <= res_slot_q;
			out_off_q    <= res_off_q;
			out_new_q    <= res_new_q;
			out_imm_q    <= res_imm_q;
			out_word_q   <= res_word_q;
		end
	end

	assign out_ch.valid           = out_valid_q;
	assign out_ch.status          = out_status_q;
	assign out_ch.found           = out_found_q;
	assign out_ch.slot_index      = 10'(out_slot_q);
	assign out_ch.data_offset     = 14'(out_off_q);
	assign out_ch.new_entry       = out_new_q;
	assign out_ch.entry_immutable = out_imm_q;
	assign out_ch.word_out        = out_word_q;

	`LPKV_ASSERT_NOW(a_sweep_blocks, clk, arst_n, state_q == S_SWEEP, !in_ch.ready,
		"item accepted during slot sweep")
	`LPKV_ASSERT_NEXT(a_accept_busy, clk, arst_n, in_acc, state_q != S_IDLE,
		"block stayed idle after accepting an item")
	`LPKV_ASSERT_NOW(a_count_range, clk, arst_n, 1'b1, entry_count_q <= ECW'(SLOTS),
		"entry count beyond table size")
	`LPKV_ASSERT_NEXT(a_out_source, clk, arst_n, state_q != S_DONE && !out_valid_q,
		!out_valid_q, "result shown without a finished item")

endmodule

// File: sim/tb_top.sv
// ----------------------------------------------------------------------------
// Key store testbench
// Drives command items into the linear-probing key store and checks every
// result item against a predictor of the slot table and the data store.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import lpkv_pkg::*;

	localparam int NSLOTS     = 1024;
	localparam int NWORDS     = 16384;
	localparam int MAXLEN     = 64;
	localparam int CYCLE_MAX  = 3000000;
	localparam int HOLD_LEN   = 300;

	typedef struct {
		cmd_t        command;
		logic [63:0] key;
		logic [5:0]  word_index;
		logic [31:0] value_word;
		logic        mark_immutable;
	} cmd_item_t;

	typedef struct {
		status_t     status;
		logic        found;
		logic [9:0]  slot_index;
		logic [13:0] data_offset;
		logic        new_entry;
		logic        entry_immutable;
		logic [31:0] word_out;
	} res_item_t;

	// The scoreboard keeps its own copy of the table, the data store and the
	// two registers. Each accepted item is applied to it at once and the
	// expected result joins the queue that the monitor drains.
	class result_board;
		logic [63:0] slot_key[NSLOTS];
		bit [13:0]   slot_off[NSLOTS];
		bit          slot_used[NSLOTS];
		bit          slot_locked[NSLOTS];
		int          entries;
		bit [31:0]   words[NWORDS];
		bit          written[NWORDS];
		bit [6:0]    vec_len;
		bit [5:0]    probe_limit;
		res_item_t   expected_q[$];
		int          errors;

		function new();
			foreach (slot_used[i]) begin
				slot_used[i] = 0;
				slot_locked[i] = 0;
				slot_off[i] = 0;
				slot_key[i] = '0;
			end
			foreach (words[i]) begin
				words[i] = 0;
				written[i] = 0;
			end
			slot_used[0] = 1;
			slot_locked[0] = 1;
			written[0] = 1;
			entries = 1;
			vec_len = VEC_LEN_RESET;
			probe_limit = PROBE_LIMIT_RESET;
			errors = 0;
		endfunction

		function int eff_len();
			if (vec_len == 0) return 1;
			if (vec_len > MAXLEN) return MAXLEN;
			return int'(vec_len);
		endfunction

		// Returns 0 on a hit, 1 on an empty slot, 2 when the probes run out.
		function int search(logic [63:0] key, output int slot);
			int idx;
			int lim;
			idx = int'(key[9:0]);
			lim = (probe_limit == 0) ? 1 : int'(probe_limit);
			if (lim > PROBE_CAP) lim = PROBE_CAP;
			slot = 0;
			for (int i = 0; i < lim; i++) begin
				if (!slot_used[idx]) begin
					slot = idx;
					return 1;
				end
				if (slot_key[idx] == key) begin
					slot = idx;
					return 0;
				end
				idx = (idx + 1) % NSLOTS;
			end
			return 2;
		endfunction

		// True when the item would return a data word that was never written.
		function bit reads_unwritten(cmd_item_t it);
			int slot;
			int r;
			int off;
			if (it.command == CMD_CLEAR || it.word_index >= eff_len()) return 0;
			r = search(it.key, slot);
			if (r == 2) return 0;
			if (r == 1) begin
				if (it.command == CMD_LOOKUP) return 0;
				off = entries * eff_len();
				if (off + eff_len() > NWORDS) return 0;
			end else begin
				off = slot_off[slot];
			end
			if (it.command == CMD_SET_WORD) return 0;
			return !written[off + it.word_index];
		endfunction

		function void note_input(cmd_item_t it);
			res_item_t r;
			int slot;
			int hit;
			int off;
			int vlen;
			r = '{ST_OK, 0, 0, 0, 0, 0, 0};
			vlen = eff_len();
			if (it.command == CMD_CLEAR) begin
				foreach (slot_used[i]) slot_used[i] = 0;
				entries = 0;
				expected_q.push_back(r);
				return;
			end
			if (it.word_index >= vlen) begin
				r.status = ST_BAD_INDEX;
				expected_q.push_back(r);
				return;
			end
			hit = search(it.key, slot);
			if (hit == 2) begin
				r.status = ST_TABLE_FULL;
				expected_q.push_back(r);
				return;
			end
			if (hit == 1) begin
				if (it.command == CMD_LOOKUP) begin
					r.status = ST_NOT_FOUND;
					expected_q.push_back(r);
					return;
				end
				off = entries * vlen;
				if (off + vlen > NWORDS) begin
					r.status = ST_DATA_FULL;
					expected_q.push_back(r);
					return;
				end
				slot_key[slot] = it.key;
				slot_off[slot] = 14'(off);
				slot_used[slot] = 1;
				slot_locked[slot] = 0;
				entries++;
				r.new_entry = 1;
			end else begin
				off = slot_off[slot];
				if (off + it.word_index >= NWORDS) begin
					r.status = ST_BAD_INDEX;
					expected_q.push_back(r);
					return;
				end
			end
			if (it.command == CMD_SET_WORD) begin
				words[off + it.word_index] = it.value_word;
				written[off + it.word_index] = 1;
				slot_locked[slot] = it.mark_immutable;
			end
			r.found = 1;
			r.slot_index = 10'(slot);
			r.data_offset = 14'(off);
			r.entry_immutable = slot_locked[slot];
			r.word_out = words[off + it.word_index];
			expected_q.push_back(r);
		endfunction

		function void check(res_item_t got);
			res_item_t e;
			if (expected_q.size() == 0) begin
				$error("result item with no expectation waiting");
				errors++;
				return;
			end
			e = expected_q.pop_front();
			if (got.status != e.status) begin
				$error("status: expected %0d, actual %0d", e.status, got.status);
				errors++;
			end
			if (got.found !== e.found) begin
				$error("found: expected %0d, actual %0d", e.found, got.found);
				errors++;
			end
			if (got.slot_index !== e.slot_index) begin
				$error("slot_index: expected %0d, actual %0d", e.slot_index, got.slot_index);
				errors++;
			end
			if (got.data_offset !== e.data_offset) begin
				$error("data_offset: expected %0d, actual %0d", e.data_offset,
					got.data_offset);
				errors++;
			end
			if (got.new_entry !== e.new_entry) begin
				$error("new_entry: expected %0d, actual %0d", e.new_entry, got.new_entry);
				errors++;
			end
			if (got.entry_immutable !== e.entry_immutable) begin
				$error("entry_immutable: expected %0d, actual %0d", e.entry_immutable,
					got.entry_immutable);
				errors++;
			end
			if (got.word_out !== e.word_out) begin
				$error("word_out: expected %h, actual %h", e.word_out, got.word_out);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	lpkv_in_if  in_ch();
	lpkv_out_if out_ch();

	linear_probe_kv_store_top dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.out_ch  (out_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	result_board sb = new();

	// Idling is switched off for the last part of the run, and one long
	// receiver hold is requested by the stimulus so that the block backs up.
	bit quiet = 0;
	bit hold_req = 0;
	int cycles = 0;
	logic [63:0] key_pool[$];

	initial clk = 0;
	always #2 clk = ~clk;

	// Watchdog: a run that stalls anywhere ends here as a failure.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_MAX) begin
			$display("linear_probe_kv_store_top: mismatch");
			$finish;
		end
	end

	// Every result item handed over is checked against the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready) begin
			sb.check('{status_t'(out_ch.status), out_ch.found, out_ch.slot_index,
				out_ch.data_offset, out_ch.new_entry, out_ch.entry_immutable,
				out_ch.word_out});
		end
	end

	// Receiver: random stall bursts, and one long hold on request.
	initial begin
		out_ch.ready = 0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_ch.ready = 0;
				hold_req = 0;
				repeat (HOLD_LEN) @(negedge clk);
			end else if (!quiet && $urandom_range(0, 9) == 0) begin
				out_ch.ready = 0;
				repeat ($urandom_range(0, 14)) @(negedge clk);
			end else begin
				out_ch.ready = 1;
			end
		end
	end

	// One register write: setup cycle, then access cycle.
	task automatic write_reg(logic idx, logic [31:0] value);
		@(negedge clk);
		psel = 1;
		pwrite = 1;
		penable = 0;
		paddr = {idx, 2'b00};
		pwdata = value;
		@(negedge clk);
		penable = 1;
		@(negedge clk);
		psel = 0;
		penable = 0;
		pwrite = 0;
		if (idx == REG_VEC_LEN) sb.vec_len = value[6:0];
		else sb.probe_limit = value[5:0];
	endtask

	// Offer one item and hold it until the block takes it. An item that would
	// read a data word nobody has written is turned into a set_word first.
	task automatic send(cmd_item_t it);
		if (sb.reads_unwritten(it)) it.command = CMD_SET_WORD;
		@(negedge clk);
		in_ch.valid = 1;
		in_ch.command = it.command;
		in_ch.key = it.key;
		in_ch.word_index = it.word_index;
		in_ch.value_word = it.value_word;
		in_ch.mark_immutable = it.mark_immutable;
		do @(posedge clk); while (!in_ch.ready);
		sb.note_input(it);
		if (!quiet && $urandom_range(0, 5) == 0) begin
			@(negedge clk);
			in_ch.valid = 0;
			repeat ($urandom_range(0, 14)) @(negedge clk);
		end
	endtask

	task automatic drain();
		@(negedge clk);
		in_ch.valid = 0;
		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic configure(logic [31:0] vlen, logic [31:0] plim);
		drain();
		write_reg(REG_VEC_LEN, vlen);
		write_reg(REG_PROBE_LIMIT, plim);
	endtask

	// Keys cluster on a handful of home slots, the table ends among them, so
	// that probes run long, wrap round and exhaust the limit.
	function automatic logic [63:0] fresh_key();
		logic [63:0] k;
		int homes[10] = '{0, 1, 2, 3, 511, 512, 1020, 1021, 1022, 1023};
		k = {$urandom, $urandom};
		if ($urandom_range(0, 4) != 0) k[9:0] = 10'(homes[$urandom_range(0, 9)]);
		key_pool.push_back(k);
		if (key_pool.size() > 64) void'(key_pool.pop_front());
		return k;
	endfunction

	function automatic cmd_item_t random_item(bit no_clear);
		cmd_item_t it;
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 30) it.command = CMD_GET_OR_ADD;
		else if (pick < 55) it.command = CMD_LOOKUP;
		else if (pick < 99 || no_clear) it.command = CMD_SET_WORD;
		else it.command = CMD_CLEAR;
		if (key_pool.size() != 0 && $urandom_range(0, 1) == 0)
			it.key = key_pool[$urandom_range(0, key_pool.size() - 1)];
		else
			it.key = fresh_key();
		if ($urandom_range(0, 9) == 0) it.word_index = 6'($urandom_range(0, 63));
		else it.word_index = 6'($urandom_range(0, sb.eff_len() - 1));
		it.value_word = $urandom;
		it.mark_immutable = 1'($urandom_range(0, 1));
		return it;
	endfunction

	task automatic random_run(int n);
		repeat (n) send(random_item(0));
	endtask

	initial begin
		arst_n = 0;
		psel = 0;
		penable = 0;
		pwrite = 0;
		paddr = '0;
		pwdata = '0;
		in_ch.valid = 0;
		in_ch.command = CMD_GET_OR_ADD;
		in_ch.key = '0;
		in_ch.word_index = '0;
		in_ch.value_word = '0;
		in_ch.mark_immutable = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		// The table is swept after reset; the block is idle once it takes items.
		do @(posedge clk); while (!in_ch.ready);

		// Directed part at the reset settings: the preset key 0 entry, its
		// immutable mark, word writes at the field extremes, a missing key,
		// a bad word index, and a clear that removes key 0 as well.
		send('{CMD_LOOKUP, 64'd0, 6'd0, 32'd0, 1'b0});
		send('{CMD_GET_OR_ADD, 64'd0, 6'd0, 32'd0, 1'b0});
		send('{CMD_SET_WORD, 64'd0, 6'd0, 32'hFFFF_FFFF, 1'b0});
		send('{CMD_LOOKUP, 64'd0, 6'd0, 32'd0, 1'b1});
		send('{CMD_SET_WORD, 64'hFFFF_FFFF_FFFF_FFFF, 6'd0, 32'h0000_0000, 1'b1});
		send('{CMD_GET_OR_ADD, 64'hFFFF_FFFF_FFFF_FFFF, 6'd0, 32'd0, 1'b0});
		send('{CMD_SET_WORD, 64'hAAAA_5555_AAAA_57FF, 6'd0, 32'h5555_AAAA, 1'b0});
		send('{CMD_LOOKUP, 64'h1234_5678_9ABC_DEF0, 6'd0, 32'd0, 1'b0});
		send('{CMD_SET_WORD, 64'd5, 6'd63, 32'h1, 1'b1});
		send('{CMD_GET_OR_ADD, 64'd400, 6'd1, 32'd0, 1'b0});
		send('{CMD_CLEAR, 64'd0, 6'd0, 32'd0, 1'b0});
		send('{CMD_LOOKUP, 64'd0, 6'd0, 32'd0, 1'b0});
		send('{CMD_GET_OR_ADD, 64'd0, 6'd0, 32'd0, 1'b0});
		send('{CMD_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 6'd0, 32'd0, 1'b0});

		// Out-of-range register values: both act as one.
		configure(0, 0);
		random_run(100);

		// Longest vectors: fill the data store until inserts report it full.
		configure(64, 63);
		repeat (262) send('{CMD_GET_OR_ADD, {$urandom, $urandom}, 6'($urandom_range(0, 63)),
			$urandom, 1'($urandom_range(0, 1))});
		repeat (50) send(random_item(1));
		send('{CMD_CLEAR, 64'd0, 6'd0, 32'd0, 1'b0});

		configure(1, 1);
		random_run(180);
		configure(3, 4);
		hold_req = 1;
		random_run(180);
		configure(127, 32);
		random_run(180);
		configure(8, 2);
		random_run(180);
		configure(2, 8);
		random_run(180);
		configure(5, 33);
		random_run(180);

		// Last part: no idling on either side.
		configure(4, 32);
		quiet = 1;
		random_run(200);

		drain();
		repeat (50) @(posedge clk);
		if (sb.errors == 0 && sb.expected_q.size() == 0) begin
			$display("linear_probe_kv_store_top: match");
		end else begin
			$display("linear_probe_kv_store_top: mismatch");
		end
		$finish;
	end
endmodule

// File: sim.f
+incdir+rtl
rtl/lpkv_pkg.sv
rtl/lpkv_if.sv
rtl/lpkv_data_store.sv
rtl/linear_probe_kv_store_top.sv
sim/tb_top.sv
